// ----- design/positional_insert_delete_list_defines.svh -----
// Assertion macros for the list block's datapath RTL file.
// Simulation gets concurrent assertions; synthesis gets empty bodies.
`ifndef POSITIONAL_INSERT_DELETE_LIST_DEFINES_SVH
`define POSITIONAL_INSERT_DELETE_LIST_DEFINES_SVH

`ifndef SYNTHESIS

// Clocked check, switched off while reset is held
`define PIDL_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("%m: assertion failed");

// Clocked check that also holds during reset
`define PIDL_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("%m: assertion failed");

`else

`define PIDL_ASSERT(lbl, clk, rstn, prop)
`define PIDL_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// ----- design/pidl_pkg.sv -----
// Shared types and constants of the positional insert/delete list.
// No dependencies; every module file of the block imports this package.
package pidl_pkg;

    // Default list capacity
    localparam int DEPTH_DEF = 16;

    // Fixed field widths
    localparam int ACT_W   = 3;
    localparam int VAL_W   = 32;
    localparam int POS_W   = 5;
    localparam int STS_W   = 2;
    localparam int OCNT_W  = 5;
    localparam int IN_W    = 40;
    localparam int OUT_W   = 40;

    // Action codes; the code left over is handled as a no-op
    typedef enum logic [ACT_W-1:0] {
        ACT_INS_FRONT = 3'd0,
        ACT_INS_END   = 3'd1,
        ACT_INS_POS   = 3'd2,
        ACT_DEL_FRONT = 3'd3,
        ACT_DEL_END   = 3'd4,
        ACT_DEL_POS   = 3'd5,
        ACT_READ      = 3'd6
    } t_action;

    // Result status codes
    typedef enum logic [STS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    // Controller to datapath commands
    typedef struct packed {
        logic load;  // capture the incoming request
        logic exec;  // apply the held request, load its single result
        logic emit;  // load the next read-out entry as a result
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;   // output register can take a result this cycle
        logic is_read;    // held request is a read-out
        logic cnt_zero;   // list is empty
        logic read_last;  // read index points at the final entry
    } t_sts;

endpackage

// ----- design/pidl_ctrl.sv -----
// Sequencer of the list block: accepts requests and steps each one through
// execution or read-out. Depends on pidl_pkg.
module pidl_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    output logic             o_req_ready,
    input  pidl_pkg::t_sts   i_sts,
    output pidl_pkg::t_cmd   o_cmd
);
    import pidl_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_READ = 3'b100
    } t_state;

    t_state r_state, n_state;

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        o_req_ready = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_sts.out_free) begin
                    if (i_sts.is_read && !i_sts.cnt_zero) begin
                        o_cmd.emit = 1'b1;
                        n_state    = i_sts.read_last ? S_IDLE : S_READ;
                    end else begin
                        o_cmd.exec = 1'b1;
                        n_state    = S_IDLE;
                    end
                end
            end
            S_READ: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.read_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- design/pidl_dp.sv -----
// Datapath of the list block: request register, entry cells with parallel
// shift, entry count, read-out index and output register. Depends on pidl_pkg.
`include "positional_insert_delete_list_defines.svh"

module pidl_dp #(
    parameter int DEPTH = pidl_pkg::DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  pidl_pkg::t_cmd                   i_cmd,
    output pidl_pkg::t_sts                   o_sts,
    input  logic [pidl_pkg::ACT_W-1:0]       i_action,
    input  logic signed [pidl_pkg::VAL_W-1:0] i_value,
    input  logic [pidl_pkg::POS_W-1:0]       i_position,
    input  logic                             i_out_ready,
    output logic                             o_out_valid,
    output logic [pidl_pkg::STS_W-1:0]       o_status,
    output logic signed [pidl_pkg::VAL_W-1:0] o_entry_value,
    output logic [pidl_pkg::OCNT_W-1:0]      o_entry_count,
    output logic                             o_last
);
    import pidl_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);
    localparam int WW = ((CW > POS_W) ? CW : POS_W) + 1;

    // Held request
    logic [ACT_W-1:0]        r_action;
    logic signed [VAL_W-1:0] r_value;
    logic [POS_W-1:0]        r_pos;

    // List state
    logic [VAL_W-1:0] r_entries [DEPTH];
    logic [VAL_W-1:0] n_entries [DEPTH];
    logic [CW-1:0]    r_count, n_count;
    logic [IW-1:0]    r_idx;

    // Output register
    logic                    r_out_valid;
    logic [STS_W-1:0]        r_out_status;
    logic signed [VAL_W-1:0] r_out_value;
    logic [OCNT_W-1:0]       r_out_count;
    logic                    r_out_last;

    // Execution decode
    t_action       act;
    t_status       ex_status;
    logic [WW-1:0] pos_w, cnt_w, slot;
    logic          full, do_ins, do_del, read_last;

    assign act   = t_action'(r_action);
    assign pos_w = WW'(r_pos);
    assign cnt_w = WW'(r_count);
    assign full  = (r_count == CW'(DEPTH));

    // Choose status and target slot for the held request
    always_comb begin
        ex_status = ST_OK;
        do_ins    = 1'b0;
        do_del    = 1'b0;
        slot      = '0;
        unique case (act)
            ACT_INS_FRONT, ACT_INS_END, ACT_INS_POS: begin
                if (full) begin
                    ex_status = ST_FULL;
                end else if (act == ACT_INS_FRONT) begin
                    do_ins = 1'b1;
                end else if (act == ACT_INS_END) begin
                    do_ins = 1'b1;
                    slot   = cnt_w;
                end else if (pos_w == '0 || pos_w > cnt_w + WW'(1)) begin
                    ex_status = ST_RANGE;
                end else begin
                    do_ins = 1'b1;
                    slot   = pos_w - WW'(1);
                end
            end
            ACT_DEL_FRONT, ACT_DEL_END, ACT_DEL_POS: begin
                if (r_count == '0) begin
                    ex_status = ST_EMPTY;
                end else if (act == ACT_DEL_FRONT) begin
                    do_del = 1'b1;
                end else if (act == ACT_DEL_END) begin
                    do_del = 1'b1;
                    slot   = cnt_w - WW'(1);
                end else if (pos_w == '0 || pos_w > cnt_w) begin
                    ex_status = ST_RANGE;
                end else begin
                    do_del = 1'b1;
                    slot   = pos_w - WW'(1);
                end
            end
            ACT_READ: begin
                // only the empty read-out reaches execution
                ex_status = ST_EMPTY;
            end
            default: begin
                ex_status = ST_OK;
            end
        endcase
    end

    // Shift all cells at once: open a gap for insert, close one for delete
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            n_entries[i] = r_entries[i];
            if (do_ins) begin
                if (WW'(i) == slot) begin
                    n_entries[i] = r_value;
                end else if (i > 0 && WW'(i) > slot) begin
                    n_entries[i] = r_entries[(i > 0) ? i - 1 : 0];
                end
            end else if (do_del) begin
                if (i < DEPTH - 1 && WW'(i) >= slot) begin
                    n_entries[i] = r_entries[(i < DEPTH - 1) ? i + 1 : i];
                end
            end
        end
        n_count = r_count;
        if (do_ins) begin
            n_count = r_count + CW'(1);
        end else if (do_del) begin
            n_count = r_count - CW'(1);
        end
    end

    assign read_last = (CW'(r_idx) + CW'(1) == r_count);

    // Request register and read index
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_action;
            r_value  <= i_value;
            r_pos    <= i_position;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_cmd.load) begin
            r_idx <= '0;
        end else if (i_cmd.emit && !read_last) begin
            r_idx <= r_idx + IW'(1);
        end
    end

    // Entry cells and count
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_entries[i] <= n_entries[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_count <= n_count;
        end
    end

    // Output register: hold until taken, load on execute or read-out step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.exec || i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_out_status <= ex_status;
            r_out_value  <= '0;
            r_out_count  <= OCNT_W'(n_count);
            r_out_last   <= 1'b1;
        end else if (i_cmd.emit) begin
            r_out_status <= ST_OK;
            r_out_value  <= r_entries[r_idx];
            r_out_count  <= OCNT_W'(r_count);
            r_out_last   <= read_last;
        end
    end

    assign o_sts.out_free  = !r_out_valid || i_out_ready;
    assign o_sts.is_read   = (act == ACT_READ);
    assign o_sts.cnt_zero  = (r_count == '0);
    assign o_sts.read_last = read_last;

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_entry_value = r_out_value;
    assign o_entry_count = r_out_count;
    assign o_last        = r_out_last;

    // Checks
    `PIDL_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CW'(DEPTH))
    `PIDL_ASSERT(a_load_when_free, i_clk, i_rst_n,
        (i_cmd.exec || i_cmd.emit) |-> o_sts.out_free)
    `PIDL_ASSERT(a_count_by_exec, i_clk, i_rst_n,
        !$stable(r_count) |-> $past(i_cmd.exec))
    `PIDL_ASSERT(a_emit_in_list, i_clk, i_rst_n,
        i_cmd.emit |-> (CW'(r_idx) < r_count))
    `PIDL_ASSERT(a_one_command, i_clk, i_rst_n,
        $countones({i_cmd.load, i_cmd.exec, i_cmd.emit}) <= 1)

endmodule

// ----- design/positional_insert_delete_list.sv -----
// Top level of the positional insert/delete list: stream ports, sequencer
// and datapath. Depends on pidl_pkg, pidl_ctrl and pidl_dp.
//
// Usage:
//   Requests arrive on the s_axis channel: an action (insert front, insert
//   end, insert at a one-based position, delete front, delete end, delete at
//   a position, read out), a value for inserts and a position. Results leave
//   on the m_axis channel with a status, an entry value, the entry count
//   after the action and tlast on the final result of each request.
//   Each request is taken in the idle state and executed once the output
//   register is free; insert and delete shift every cell at once and give
//   one result. A read-out gives one result per entry, one per cycle while
//   the output register is free, from the single read port on the cell row,
//   and a single empty result for an empty list. A new request is taken
//   while the last result still sits in the output register.
//   Reset empties the list at once; entry cells are not cleared, since only
//   entries below the count are ever read.
//   When the receiver holds tready low the output register keeps its result
//   and execution waits; a pending request is held, not lost.
module positional_insert_delete_list #(
    parameter int DEPTH = pidl_pkg::DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // tdata: action[2:0], value[34:3], position[39:35]
    input  logic [pidl_pkg::IN_W-1:0]  s_axis_tdata,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // tdata: status[1:0], entry_value[33:2], entry_count[38:34], zero[39]
    output logic [pidl_pkg::OUT_W-1:0] m_axis_tdata,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic                       m_axis_tlast
);
    import pidl_pkg::*;

    t_cmd                    cmd;
    t_sts                    sts;
    logic [STS_W-1:0]        out_status;
    logic signed [VAL_W-1:0] out_value;
    logic [OCNT_W-1:0]       out_count;

    pidl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    pidl_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_action      (s_axis_tdata[2:0]),
        .i_value       (s_axis_tdata[34:3]),
        .i_position    (s_axis_tdata[39:35]),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_status      (out_status),
        .o_entry_value (out_value),
        .o_entry_count (out_count),
        .o_last        (m_axis_tlast)
    );

    // Pack result fields from the lowest bit up
    assign m_axis_tdata = {1'b0, out_count, out_value, out_status};

endmodule
